// ----- src/mmln_pkg.sv -----
// Shared constants, types and a helper function of the min/max level normaliser.
`timescale 1ns / 1ps

package mmln_pkg;

    // Field widths.
    localparam int VOXEL_W     = 32;
    localparam int LEVEL_W     = 31;
    localparam int STATUS_W    = 2;
    localparam int CMD_W       = 2;
    localparam int FORMAT_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = LEVEL_W;

    // Command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Divider sizing: the product holds VOXEL_W + LEVEL_W bits, one quotient bit per step.
    localparam int PROD_W = VOXEL_W + LEVEL_W;
    localparam int STEP_W = $clog2(LEVEL_W);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAP     = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEVEL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA   = 2'd2;

    // Sample format codes.
    localparam logic [FORMAT_W-1:0] FORMAT_U8  = 2'd0;
    localparam logic [FORMAT_W-1:0] FORMAT_S16 = 2'd1;
    localparam logic [FORMAT_W-1:0] FORMAT_S32 = 2'd2;

    // Configuration register indices.
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_FORMAT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEVEL     = 1'd1;

    // Reset values.
    localparam logic [FORMAT_W-1:0]       FORMAT_RESET    = FORMAT_U8;
    localparam logic [LEVEL_W-1:0]        MAX_LEVEL_RESET = 31'd255;
    localparam logic signed [VOXEL_W-1:0] MINIMUM_RESET   = 32'sh7FFF_FFFF;
    localparam logic signed [VOXEL_W-1:0] MAXIMUM_RESET   = 32'sh0000_0000;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [FORMAT_W-1:0] sample_format;
        logic [LEVEL_W-1:0]  max_level;
    } cfg_t;

    // One map request with the statistics captured at its acceptance.
    typedef struct packed {
        logic signed [VOXEL_W-1:0] voxel_value;
        logic signed [VOXEL_W-1:0] minimum;
        logic signed [VOXEL_W-1:0] maximum;
    } map_item_t;

    // Queue status towards both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Largest level that a sample format can represent; zero for an unknown format.
    function automatic logic [LEVEL_W-1:0] format_top(input logic [FORMAT_W-1:0] fmt);
        logic [LEVEL_W-1:0] top;
        case (fmt)
            FORMAT_U8:  top = 31'd255;
            FORMAT_S16: top = 31'd32767;
            FORMAT_S32: top = 31'h7FFF_FFFF;
            default:    top = '0;
        endcase
        return top;
    endfunction

endpackage

// ----- src/mmln_front.sv -----
// Front end: accepts commands, keeps the running statistics and queues map requests.
`timescale 1ns / 1ps

module mmln_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mmln_pkg::CMD_W-1:0]           s_command,
    input  logic signed [mmln_pkg::VOXEL_W-1:0]  s_voxel_value,
    input  mmln_pkg::queue_status_t              q_status,
    output logic                                 push_valid,
    output mmln_pkg::map_item_t                  push_item
);

    logic signed [mmln_pkg::VOXEL_W-1:0] minimum_reg, minimum_next;
    logic signed [mmln_pkg::VOXEL_W-1:0] maximum_reg, maximum_next;
    logic                                accept;

    // A command is taken whenever the queue has room for a possible map request.
    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // Statistics update for clear and measure commands.
    always_comb begin
        minimum_next = minimum_reg;
        maximum_next = maximum_reg;
        if (accept) begin
            case (s_command)
                mmln_pkg::CMD_CLEAR: begin
                    minimum_next = mmln_pkg::MINIMUM_RESET;
                    maximum_next = mmln_pkg::MAXIMUM_RESET;
                end
                mmln_pkg::CMD_MEASURE: begin
                    if (s_voxel_value > maximum_reg) begin
                        maximum_next = s_voxel_value;
                    end
                    if (s_voxel_value < minimum_reg) begin
                        minimum_next = s_voxel_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minimum_reg <= mmln_pkg::MINIMUM_RESET;
            maximum_reg <= mmln_pkg::MAXIMUM_RESET;
        end else begin
            minimum_reg <= minimum_next;
            maximum_reg <= maximum_next;
        end
    end

    // A map request carries the statistics as they stand at its transfer.
    assign push_valid            = accept && (s_command == mmln_pkg::CMD_MAP);
    assign push_item.voxel_value = s_voxel_value;
    assign push_item.minimum     = minimum_reg;
    assign push_item.maximum     = maximum_reg;

endmodule

// ----- src/mmln_queue.sv -----
// Short first-in first-out queue of map requests between the front and back ends.
`timescale 1ns / 1ps

module mmln_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mmln_pkg::map_item_t     push_item,
    input  logic                    pop,
    output mmln_pkg::map_item_t     pop_item,
    output mmln_pkg::queue_status_t status
);

    mmln_pkg::map_item_t                entry_reg [mmln_pkg::QUEUE_DEPTH];
    logic [mmln_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [mmln_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [mmln_pkg::QCOUNT_W-1:0]      count_reg, count_next;

    localparam logic [mmln_pkg::QPTR_W-1:0] LastPtr =
        mmln_pkg::QPTR_W'(mmln_pkg::QUEUE_DEPTH - 1);

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == mmln_pkg::QCOUNT_W'(mmln_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ----- src/mmln_back.sv -----
// Back end: checks, scales and divides one map request, then presents the result.
`timescale 1ns / 1ps

module mmln_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mmln_pkg::cfg_t                    cfg,
    input  mmln_pkg::queue_status_t           q_status,
    output logic                              pop,
    input  mmln_pkg::map_item_t               pop_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mmln_pkg::LEVEL_W-1:0]      m_level,
    output logic [mmln_pkg::STATUS_W-1:0]     m_status
);

    localparam int VW = mmln_pkg::VOXEL_W;
    localparam int LW = mmln_pkg::LEVEL_W;
    localparam int SW = mmln_pkg::STATUS_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    mmln_pkg::map_item_t            item_reg, item_next;
    logic [SW-1:0]                  status_reg, status_next;
    logic                           zero_reg, zero_next;
    logic [VW-1:0]                  range_reg, range_next;
    logic [VW-1:0]                  diff_reg, diff_next;
    logic [VW-1:0]                  rem_reg, rem_next;
    logic [LW-1:0]                  low_reg, low_next;
    logic [LW-1:0]                  quo_reg, quo_next;
    logic [mmln_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [LW-1:0]                  res_level_reg, res_level_next;
    logic [SW-1:0]                  res_status_reg, res_status_next;
    logic                           m_valid_reg, m_valid_next;
    logic [LW-1:0]                  m_level_reg, m_level_next;
    logic [SW-1:0]                  m_status_reg, m_status_next;

    logic [LW-1:0]                  top;
    logic [mmln_pkg::PROD_W-1:0]    product;
    logic [VW:0]                    rem_shift;
    logic                           fits;
    logic                           load_out;

    // Working values of the individual steps.
    assign top       = mmln_pkg::format_top(cfg.sample_format);
    assign product   = mmln_pkg::PROD_W'(diff_reg) * mmln_pkg::PROD_W'(cfg.max_level);
    assign rem_shift = {rem_reg, low_reg[LW-1]};
    assign fits      = (rem_shift >= {1'b0, range_reg});
    assign load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Sequencer for one map request.
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        zero_next       = zero_reg;
        range_next      = range_reg;
        diff_next       = diff_reg;
        rem_next        = rem_reg;
        low_next        = low_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        res_level_next  = res_level_reg;
        res_status_next = res_status_reg;
        pop             = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    item_next  = pop_item;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // The level check takes precedence over the missing data check.
                if (cfg.max_level == '0 || cfg.max_level > top) begin
                    status_next = mmln_pkg::STATUS_BAD_LEVEL;
                end else if (item_reg.maximum < item_reg.minimum) begin
                    status_next = mmln_pkg::STATUS_NO_DATA;
                end else begin
                    status_next = mmln_pkg::STATUS_OK;
                end
                zero_next  = !(item_reg.voxel_value > item_reg.minimum);
                range_next = item_reg.maximum - item_reg.minimum;
                diff_next  = item_reg.voxel_value - item_reg.minimum;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // The product feeds the divider; its upper half is below the range here.
                rem_next  = product[mmln_pkg::PROD_W-1:LW];
                low_next  = product[LW-1:0];
                quo_next  = '0;
                step_next = mmln_pkg::STEP_W'(LW - 1);
                res_status_next = status_reg;
                if (status_reg != mmln_pkg::STATUS_OK || zero_reg || range_reg == '0) begin
                    res_level_next = '0;
                    state_next     = ST_DONE;
                end else if (diff_reg >= range_reg) begin
                    // At or above the maximum the level saturates.
                    res_level_next = cfg.max_level;
                    state_next     = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                rem_next  = fits ? VW'(rem_shift - {1'b0, range_reg}) : rem_shift[VW-1:0];
                low_next  = {low_reg[LW-2:0], 1'b0};
                quo_next  = {quo_reg[LW-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    res_level_next = {quo_reg[LW-2:0], fits};
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: holds a result until its transfer.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_level_next  = m_level_reg;
        m_status_next = m_status_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_level_next  = res_level_reg;
            m_status_next = res_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        status_reg     <= status_next;
        zero_reg       <= zero_next;
        range_reg      <= range_next;
        diff_reg       <= diff_next;
        rem_reg        <= rem_next;
        low_reg        <= low_next;
        quo_reg        <= quo_next;
        step_reg       <= step_next;
        res_level_reg  <= res_level_next;
        res_status_reg <= res_status_next;
        m_level_reg    <= m_level_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_level  = m_level_reg;
    assign m_status = m_status_reg;

endmodule

// ----- src/min_max_level_normalizer_core.sv -----
// Top level of the min/max level normaliser: configuration registers and the two ends.
//
//  Channel   Ports                                    Direction
//  input     s_valid s_ready s_command s_voxel_value  in
//  result    m_valid m_ready m_level m_status         out
//  config    cfg_valid cfg_ready cfg_index cfg_data   in
//
// Clear and measure commands take effect in the cycle of their transfer.
// A map command passes the queue, check and multiply steps, then a 31-step
// restoring divider at one quotient bit per cycle; saturated or zero levels
// skip the divider. The back end works on one map request at a time.
// A two-entry queue lets commands keep arriving while the divider is busy, until it fills.
// Synchronous active-low reset; no clearing pass is needed after it.
`timescale 1ns / 1ps

module min_max_level_normalizer_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mmln_pkg::CMD_W-1:0]             s_command,
    input  logic signed [mmln_pkg::VOXEL_W-1:0]    s_voxel_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mmln_pkg::LEVEL_W-1:0]           m_level,
    output logic [mmln_pkg::STATUS_W-1:0]          m_status,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mmln_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mmln_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [mmln_pkg::FORMAT_W-1:0] format_reg, format_next;
    logic [mmln_pkg::LEVEL_W-1:0]  max_level_reg, max_level_next;
    mmln_pkg::cfg_t                cfg;
    mmln_pkg::queue_status_t       q_status;
    mmln_pkg::map_item_t           push_item;
    mmln_pkg::map_item_t           pop_item;
    logic                          push_valid;
    logic                          pop;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb begin
        format_next    = format_reg;
        max_level_next = max_level_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mmln_pkg::CFG_SAMPLE_FORMAT: format_next    = cfg_data[mmln_pkg::FORMAT_W-1:0];
                mmln_pkg::CFG_MAX_LEVEL:     max_level_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg    <= mmln_pkg::FORMAT_RESET;
            max_level_reg <= mmln_pkg::MAX_LEVEL_RESET;
        end else begin
            format_reg    <= format_next;
            max_level_reg <= max_level_next;
        end
    end

    assign cfg.sample_format = format_reg;
    assign cfg.max_level     = max_level_reg;

    mmln_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_voxel_value (s_voxel_value),
        .q_status      (q_status),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    mmln_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    mmln_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_status (q_status),
        .pop      (pop),
        .pop_item (pop_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_level  (m_level),
        .m_status (m_status)
    );

endmodule

// ----- src/mmln_checker.sv -----
// Port-level checker of the min/max level normaliser, bound to the top level.
`timescale 1ns / 1ps

module mmln_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic [mmln_pkg::CMD_W-1:0]             s_command,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic [mmln_pkg::LEVEL_W-1:0]           m_level,
    input logic [mmln_pkg::STATUS_W-1:0]          m_status
);

    logic [2:0] pending_reg, pending_next;
    logic       map_in;
    logic       res_out;

    // Map requests whose result has not yet been transferred.
    assign map_in  = s_valid && s_ready && (s_command == mmln_pkg::CMD_MAP);
    assign res_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (map_in && !res_out) begin
            pending_next = pending_reg + 1'b1;
        end else if (res_out && !map_in) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Every result answers an earlier map request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_out |-> pending_reg != '0)
        else $error("result transferred without an outstanding map request");

    // A failed check always reports level zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != mmln_pkg::STATUS_OK |-> m_level == '0)
        else $error("non-zero level with a failing status");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_status))
        else $error("stalled result changed");

    // No result is shown straight after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind min_max_level_normalizer_core mmln_checker u_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the min/max level normaliser core.
`timescale 1ns / 1ps

module testbench;

    // Codes that the package leaves unnamed.
    localparam logic [mmln_pkg::CMD_W-1:0]    CMD_UNUSED  = 2'd3;
    localparam logic [mmln_pkg::FORMAT_W-1:0] FORMAT_NONE = 2'd3;

    localparam int DRAIN_CYCLES   = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 145;

    typedef struct packed {
        logic [mmln_pkg::CMD_W-1:0]          command;
        logic signed [mmln_pkg::VOXEL_W-1:0] voxel;
    } voxel_cmd_t;

    typedef struct packed {
        logic [mmln_pkg::LEVEL_W-1:0]  level;
        logic [mmln_pkg::STATUS_W-1:0] status;
    } level_result_t;

    logic                                  aclk          = 1'b0;
    logic                                  aresetn       = 1'b0;
    logic                                  s_valid       = 1'b0;
    logic                                  s_ready;
    logic [mmln_pkg::CMD_W-1:0]            s_command     = mmln_pkg::CMD_CLEAR;
    logic signed [mmln_pkg::VOXEL_W-1:0]   s_voxel_value = '0;
    logic                                  m_valid;
    logic                                  m_ready       = 1'b0;
    logic [mmln_pkg::LEVEL_W-1:0]          m_level;
    logic [mmln_pkg::STATUS_W-1:0]         m_status;
    logic                                  cfg_valid     = 1'b0;
    logic                                  cfg_ready;
    logic [mmln_pkg::CFG_INDEX_W-1:0]      cfg_index     = mmln_pkg::CFG_SAMPLE_FORMAT;
    logic [mmln_pkg::CFG_DATA_W-1:0]       cfg_data      = '0;

    // Commands waiting to be sent and levels waiting to come back.
    voxel_cmd_t    pending_cmds[$];
    level_result_t expected_levels[$];

    // Shadow copy of the registers and of the running statistics.
    logic [mmln_pkg::FORMAT_W-1:0]       shadow_format    = mmln_pkg::FORMAT_RESET;
    logic [mmln_pkg::LEVEL_W-1:0]        shadow_max_level = mmln_pkg::MAX_LEVEL_RESET;
    logic signed [mmln_pkg::VOXEL_W-1:0] stat_min         = mmln_pkg::MINIMUM_RESET;
    logic signed [mmln_pkg::VOXEL_W-1:0] stat_max         = mmln_pkg::MAXIMUM_RESET;

    bit no_idle       = 1'b0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int failures      = 0;
    int queued_items  = 0;
    int sent_items    = 0;
    int levels_checked = 0;
    int settings_run  = 1;
    int status_counts[3] = '{0, 0, 0};

    min_max_level_normalizer_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_voxel_value (s_voxel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_status      (m_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Highest level that each sample format can carry.
    function automatic logic [mmln_pkg::LEVEL_W-1:0] level_ceiling(
        input logic [mmln_pkg::FORMAT_W-1:0] fmt);
        case (fmt)
            mmln_pkg::FORMAT_U8:  return 31'd255;
            mmln_pkg::FORMAT_S16: return 31'd32767;
            mmln_pkg::FORMAT_S32: return 31'h7FFF_FFFF;
            default:              return '0;
        endcase
    endfunction

    // Level and status of a mapped voxel against the present statistics.
    function automatic level_result_t stretch_level(
        input logic signed [mmln_pkg::VOXEL_W-1:0] v);
        level_result_t r;
        longint        lo;
        longint        hi;
        longint        vv;
        logic [63:0]   span;
        logic [63:0]   product;
        logic [63:0]   quotient;
        r.level  = '0;
        r.status = mmln_pkg::STATUS_OK;
        lo = stat_min;
        hi = stat_max;
        vv = v;
        if (shadow_max_level == 0 || shadow_max_level > level_ceiling(shadow_format)) begin
            r.status = mmln_pkg::STATUS_BAD_LEVEL;
        end else if (hi < lo) begin
            r.status = mmln_pkg::STATUS_NO_DATA;
        end else if (hi > lo && vv > lo) begin
            span     = hi - lo;
            product  = (vv - lo) * longint'(shadow_max_level);
            quotient = product / span;
            if (quotient > shadow_max_level) begin
                quotient = shadow_max_level;
            end
            r.level = quotient[mmln_pkg::LEVEL_W-1:0];
        end
        return r;
    endfunction

    // Sender: offers queued commands and tracks the statistics on each transfer.
    always @(posedge aclk) begin
        level_result_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sent_items++;
                case (s_command)
                    mmln_pkg::CMD_CLEAR: begin
                        stat_min = mmln_pkg::MINIMUM_RESET;
                        stat_max = mmln_pkg::MAXIMUM_RESET;
                    end
                    mmln_pkg::CMD_MEASURE: begin
                        if (s_voxel_value > stat_max) stat_max = s_voxel_value;
                        if (s_voxel_value < stat_min) stat_min = s_voxel_value;
                    end
                    mmln_pkg::CMD_MAP: begin
                        r = stretch_level(s_voxel_value);
                        expected_levels.push_back(r);
                        status_counts[r.status]++;
                    end
                    default: begin
                        // The unused command is dropped by the block.
                    end
                endcase
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
                    voxel_cmd_t c;
                    c = pending_cmds.pop_front();
                    s_valid       <= 1'b1;
                    s_command     <= c.command;
                    s_voxel_value <= c.voxel;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus the requested long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    // Result checker against the oldest expected level.
    always @(posedge aclk) begin
        level_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_levels.size() == 0) begin
                $error("unexpected result: level %0d status %0d", m_level, m_status);
                failures++;
            end else begin
                e = expected_levels.pop_front();
                levels_checked++;
                if (m_level !== e.level) begin
                    $error("level: expected %0d, actual %0d", e.level, m_level);
                    failures++;
                end
                if (m_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_status);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", stall_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_command(input logic [mmln_pkg::CMD_W-1:0] cmd,
                                 input logic signed [mmln_pkg::VOXEL_W-1:0] v);
        voxel_cmd_t c;
        c.command = cmd;
        c.voxel   = v;
        pending_cmds.push_back(c);
        queued_items++;
    endtask

    // Voxel mostly within the format's range, sometimes anywhere in 32 bits.
    function automatic logic signed [mmln_pkg::VOXEL_W-1:0] random_voxel(
        input logic [mmln_pkg::FORMAT_W-1:0] fmt);
        logic signed [mmln_pkg::VOXEL_W-1:0] v;
        int                                  pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            v = 32'sh8000_0000;
        end else if (pick < 8) begin
            v = 32'sh7FFF_FFFF;
        end else if (pick < 18 || fmt == mmln_pkg::FORMAT_S32 || fmt == FORMAT_NONE) begin
            v = $urandom;
        end else if (fmt == mmln_pkg::FORMAT_U8) begin
            v = $urandom_range(255);
        end else begin
            v = $urandom_range(65535);
            v = v - 32'sd32768;
        end
        return v;
    endfunction

    // One stretch sequence: mostly clear, measure, then map; the rest is noise.
    task automatic queue_stretch_sequence(input logic [mmln_pkg::FORMAT_W-1:0] fmt);
        logic signed [mmln_pkg::VOXEL_W-1:0] v;
        int                                  pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // Flat volume: every measured voxel is the same.
            v = random_voxel(fmt);
            queue_command(mmln_pkg::CMD_CLEAR, random_voxel(fmt));
            repeat ($urandom_range(1, 4)) queue_command(mmln_pkg::CMD_MEASURE, v);
            queue_command(mmln_pkg::CMD_MAP, v);
            repeat ($urandom_range(1, 4)) queue_command(mmln_pkg::CMD_MAP, random_voxel(fmt));
        end else if (pick < 80) begin
            queue_command(mmln_pkg::CMD_CLEAR, random_voxel(fmt));
            repeat ($urandom_range(1, 16)) begin
                queue_command(mmln_pkg::CMD_MEASURE, random_voxel(fmt));
            end
            repeat ($urandom_range(1, 12)) queue_command(mmln_pkg::CMD_MAP, random_voxel(fmt));
        end else if (pick < 88) begin
            // Maps with nothing measured since the clear.
            queue_command(mmln_pkg::CMD_CLEAR, random_voxel(fmt));
            repeat ($urandom_range(1, 3)) queue_command(mmln_pkg::CMD_MAP, random_voxel(fmt));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                queue_command(logic'($urandom_range(3)) ?
                              mmln_pkg::CMD_W'($urandom_range(3)) : CMD_UNUSED, $urandom);
            end
        end
    endtask

    // Waits until the block has nothing left in flight.
    task automatic wait_until_drained();
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_levels.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [mmln_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [mmln_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            mmln_pkg::CFG_SAMPLE_FORMAT: shadow_format    = data[mmln_pkg::FORMAT_W-1:0];
            mmln_pkg::CFG_MAX_LEVEL:     shadow_max_level = data;
            default:                     ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // One register setting followed by random stretch sequences.
    task automatic run_setting(input logic [mmln_pkg::FORMAT_W-1:0] fmt,
                               input logic [mmln_pkg::LEVEL_W-1:0] top,
                               input bit quiet, input bit hold_off);
        int target;
        write_register(mmln_pkg::CFG_SAMPLE_FORMAT, mmln_pkg::CFG_DATA_W'(fmt));
        write_register(mmln_pkg::CFG_MAX_LEVEL, top);
        settings_run++;
        @(negedge aclk);
        no_idle = quiet;
        if (hold_off) hold_requests++;
        target = queued_items + PHASE_ITEMS;
        while (queued_items < target) queue_stretch_sequence(fmt);
        wait_until_drained();
        no_idle = 1'b0;
    endtask

    // Stimulus.
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset setting: 8-bit samples, top level 255.
        queue_command(mmln_pkg::CMD_MAP, 32'sd10);             // no data since reset
        queue_command(CMD_UNUSED, 32'sd77);                    // ignored command
        queue_command(mmln_pkg::CMD_MEASURE, 32'sd0);
        queue_command(mmln_pkg::CMD_MAP, 32'sd0);              // flat volume
        queue_command(mmln_pkg::CMD_MEASURE, 32'sd255);
        queue_command(mmln_pkg::CMD_MAP, 32'sd0);
        queue_command(mmln_pkg::CMD_MAP, 32'sd255);
        queue_command(mmln_pkg::CMD_MAP, 32'sd128);
        queue_command(mmln_pkg::CMD_MAP, -32'sd5);             // below the minimum
        queue_command(mmln_pkg::CMD_MAP, 32'sd1000);           // above the maximum
        queue_command(mmln_pkg::CMD_MAP, 32'sh8000_0000);
        queue_command(mmln_pkg::CMD_MAP, 32'sh7FFF_FFFF);
        queue_command(mmln_pkg::CMD_CLEAR, 32'sd0);
        queue_command(mmln_pkg::CMD_MAP, 32'sd3);              // no data after a clear
        queue_command(mmln_pkg::CMD_MEASURE, 32'sd100);
        queue_command(mmln_pkg::CMD_MEASURE, 32'sd100);
        queue_command(mmln_pkg::CMD_MAP, 32'sd100);            // flat volume again
        queue_command(mmln_pkg::CMD_CLEAR, 32'sd0);
        queue_command(mmln_pkg::CMD_MEASURE, 32'sh8000_0000);  // voxels outside the format
        queue_command(mmln_pkg::CMD_MEASURE, 32'sh7FFF_FFFF);
        queue_command(mmln_pkg::CMD_MAP, 32'sd0);
        queue_command(mmln_pkg::CMD_MAP, -32'sd1);
        queue_command(mmln_pkg::CMD_MAP, 32'sh7FFF_FFFE);
        wait_until_drained();

        // Random part over a range of settings, the extremes among them.
        run_setting(mmln_pkg::FORMAT_U8,  31'd255,       1'b0, 1'b0);
        run_setting(mmln_pkg::FORMAT_U8,  31'd1,         1'b0, 1'b0);
        run_setting(mmln_pkg::FORMAT_S16, 31'd32767,     1'b0, 1'b0);
        run_setting(mmln_pkg::FORMAT_S16, 31'd1000,      1'b0, 1'b1);
        run_setting(mmln_pkg::FORMAT_S32, 31'h7FFF_FFFF, 1'b1, 1'b0);
        run_setting(mmln_pkg::FORMAT_S32,
                    mmln_pkg::LEVEL_W'($urandom_range(2, 32'h7FFF_FFFE)), 1'b0, 1'b0);
        run_setting(mmln_pkg::FORMAT_U8,  31'd0,         1'b0, 1'b0);
        run_setting(mmln_pkg::FORMAT_U8,  31'd256,       1'b0, 1'b0);
        run_setting(FORMAT_NONE,          31'd5,         1'b0, 1'b0);
        run_setting(mmln_pkg::FORMAT_S16, 31'd40000,     1'b0, 1'b0);
        run_setting(mmln_pkg::FORMAT_S32, 31'd1,         1'b0, 1'b1);

        wait_until_drained();
        if (expected_levels.size() != 0) begin
            $error("%0d expected levels never arrived", expected_levels.size());
            failures++;
        end

        $display("Sent %0d commands over %0d register settings and checked %0d levels.",
                 sent_items, settings_run, levels_checked);
        $display("Statuses seen: %0d ok, %0d invalid top level, %0d no data.",
                 status_counts[0], status_counts[1], status_counts[2]);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/mmln_pkg.sv
src/mmln_front.sv
src/mmln_queue.sv
src/mmln_back.sv
src/min_max_level_normalizer_core.sv
src/mmln_checker.sv
tb/sv/testbench.sv
